FILE: rtl/keq_pkg.sv
// ----------------------------------------------------------------------------
// keq_pkg
// Shared widths, codes and control types of the key event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package keq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int NUM_KEYS    = 768;

	localparam int ACTION_W = 2;
	localparam int TYPE_W   = 5;
	localparam int CODE_W   = 10;
	localparam int VALUE_W  = 16;
	localparam int STATE_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int THR_W    = 8;
	localparam int ACC_W    = 18;

	localparam logic [THR_W-1:0] THR_RESET = 8'd3;

	localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
	localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_REL  = 5'd2;

	localparam logic [CODE_W-1:0] AXIS_Y        = 10'd1;
	localparam logic [CODE_W-1:0] FAKE_KEY_DOWN = 10'd108;
	localparam logic [CODE_W-1:0] FAKE_KEY_UP   = 10'd103;

	typedef enum logic [ACTION_W-1:0] {
		ACT_EVENT = 2'd0,
		ACT_POP   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic sweep;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/keq_evt_if.sv
// ----------------------------------------------------------------------------
// keq_evt_if
// Request channel: action and input event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface keq_evt_if;
	logic                                valid;
	logic                                ready;
	logic [keq_pkg::ACTION_W-1:0]        action;
	logic [keq_pkg::TYPE_W-1:0]          event_type;
	logic [keq_pkg::CODE_W-1:0]          event_code;
	logic signed [keq_pkg::VALUE_W-1:0]  event_value;

	modport source (output valid, action, event_type, event_code, event_value, input ready);
	modport sink   (input valid, action, event_type, event_code, event_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/keq_res_if.sv
// ----------------------------------------------------------------------------
// keq_res_if
// Result channel: popped key, key state, queue status.
// ----------------------------------------------------------------------------
`default_nettype none

interface keq_res_if;
	logic                                valid;
	logic                                ready;
	logic                                key_valid;
	logic [keq_pkg::CODE_W-1:0]          key_code;
	logic signed [keq_pkg::STATE_W-1:0]  key_state;
	logic                                queued;
	logic                                dropped;
	logic [keq_pkg::COUNT_W-1:0]         queue_count;

	modport source (output valid, key_valid, key_code, key_state, queued, dropped,
		queue_count, input ready);
	modport sink   (input valid, key_valid, key_code, key_state, queued, dropped,
		queue_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/keq_cfg_if.sv
// ----------------------------------------------------------------------------
// keq_cfg_if
// Configuration write channel for the motion threshold.
// ----------------------------------------------------------------------------
`default_nettype none

interface keq_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [keq_pkg::THR_W-1:0]     data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/keq_ctrl.sv
// ----------------------------------------------------------------------------
// keq_ctrl
// Sequencer: clearing pass after reset, capture, execute, output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module keq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output keq_pkg::cmd_t      cmd,
	input  wire keq_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_SWEEP,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.sweep   = (state_q == S_SWEEP);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					if (sts.sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_SWEEP;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/keq_dp.sv
// ----------------------------------------------------------------------------
// keq_dp
// Datapath: motion accumulator, key state memory, key queue, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module keq_dp #(
	parameter int QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH,
	parameter int NUM_KEYS    = keq_pkg::NUM_KEYS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire keq_pkg::cmd_t                       cmd,
	output keq_pkg::sts_t                            sts,
	input  wire logic                                cfg_we,
	input  wire logic [keq_pkg::THR_W-1:0]           cfg_data,
	input  wire logic [keq_pkg::ACTION_W-1:0]        action,
	input  wire logic [keq_pkg::TYPE_W-1:0]          event_type,
	input  wire logic [keq_pkg::CODE_W-1:0]          event_code,
	input  wire logic signed [keq_pkg::VALUE_W-1:0]  event_value,
	output logic                                     key_valid,
	output logic [keq_pkg::CODE_W-1:0]               key_code,
	output logic signed [keq_pkg::STATE_W-1:0]       key_state,
	output logic                                     queued,
	output logic                                     dropped,
	output logic [keq_pkg::COUNT_W-1:0]              queue_count
);

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int KW    = $clog2(NUM_KEYS);
	localparam int ACC_W = keq_pkg::ACC_W;
	localparam int CDW   = keq_pkg::CODE_W;
	localparam int SW    = keq_pkg::STATE_W;

	localparam logic [AW:0]    QD_SUM    = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [AW-1:0]  HEAD_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0]  QD_COUNT  = CW'(QUEUE_DEPTH);
	localparam logic [CDW:0]   KEY_LIM   = (CDW + 1)'(NUM_KEYS);
	localparam logic [KW-1:0]  SWEEP_END = KW'(NUM_KEYS - 1);

	logic [SW-1:0]  tbl_mem [NUM_KEYS];
	logic [CDW-1:0] fifo_mem [QUEUE_DEPTH];

	keq_pkg::action_t                   act_q;
	logic [keq_pkg::TYPE_W-1:0]         type_q;
	logic [CDW-1:0]                     code_q;
	logic signed [keq_pkg::VALUE_W-1:0] value_q;
	logic [SW-1:0]                      tbl_rd_q;
	logic [CDW-1:0]                     fifo_rd_q;

	logic signed [ACC_W-1:0] acc_q;
	logic [AW-1:0]           head_q;
	logic [CW-1:0]           count_q;
	logic [keq_pkg::THR_W-1:0] thr_q;
	logic [KW-1:0]           sweep_q;

	logic                    key_valid_q;
	logic [CDW-1:0]          key_code_q;
	logic [SW-1:0]           key_state_q;
	logic                    queued_q;
	logic                    dropped_q;
	logic [keq_pkg::COUNT_W-1:0] queue_count_q;

	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] thr_pos;
	logic signed [ACC_W-1:0] thr_neg;
	logic signed [ACC_W-1:0] acc_next;
	logic                    is_event;
	logic                    rel_y;
	logic                    over;
	logic                    under;
	logic                    fake;
	logic [CDW-1:0]          eff_code;
	logic                    key_hit;
	logic                    tbl_we;
	logic                    press;
	logic                    room;
	logic                    push;
	logic                    drop;
	logic                    pop;
	logic                    clear;
	logic [AW:0]             slot_sum;
	logic [AW:0]             slot_wrap;
	logic [AW-1:0]           slot;
	logic [AW-1:0]           head_next;
	logic [CW-1:0]           count_next;
	logic [31:0]             count_ext;
	logic [SW-1:0]           state_rd;
	logic                    mem_we;
	logic [KW-1:0]           mem_addr;
	logic [SW-1:0]           mem_data;

	always_comb begin
		is_event = (act_q == keq_pkg::ACT_EVENT);
		clear    = (act_q == keq_pkg::ACT_CLEAR);
		acc_sum  = acc_q + ACC_W'(value_q);
		thr_pos  = $signed({{(ACC_W - keq_pkg::THR_W){1'b0}}, thr_q});
		thr_neg  = -thr_pos;
		rel_y    = (type_q == keq_pkg::TYPE_REL) && (code_q == keq_pkg::AXIS_Y);
		over     = (acc_sum > thr_pos);
		under    = (acc_sum < thr_neg);
		fake     = rel_y && (over || under);

		acc_next = acc_q;
		if (is_event) begin
			if (type_q == keq_pkg::TYPE_SYNC) begin
				acc_next = acc_q;
			end else if (type_q == keq_pkg::TYPE_REL) begin
				if (rel_y) begin
					acc_next = fake ? '0 : acc_sum;
				end
			end else begin
				acc_next = '0;
			end
		end

		eff_code = fake ? (over ? keq_pkg::FAKE_KEY_DOWN : keq_pkg::FAKE_KEY_UP) : code_q;
		key_hit  = is_event && ((type_q == keq_pkg::TYPE_KEY) || fake)
			&& ({1'b0, eff_code} < KEY_LIM);
		tbl_we   = key_hit && !fake;
		press    = fake || (value_q > 16'sd0);
		room     = (count_q < QD_COUNT);
		push     = key_hit && press && room;
		drop     = key_hit && press && !room;
		pop      = (act_q == keq_pkg::ACT_POP) && (count_q != '0);

		slot_sum  = (AW + 1)'(head_q) + (AW + 1)'(count_q);
		slot_wrap = (slot_sum >= QD_SUM) ? (slot_sum - QD_SUM) : slot_sum;
		slot      = slot_wrap[AW-1:0];

		if (pop) begin
			head_next = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
		end else if (clear) begin
			head_next = '0;
		end else begin
			head_next = head_q;
		end

		if (push) begin
			count_next = count_q + CW'(1);
		end else if (pop) begin
			count_next = count_q - CW'(1);
		end else if (clear) begin
			count_next = '0;
		end else begin
			count_next = count_q;
		end
		count_ext = 32'(count_next);

		state_rd = ((act_q == keq_pkg::ACT_READ) && ({1'b0, code_q} < KEY_LIM))
			? tbl_rd_q : '0;

		mem_we   = cmd.sweep || (cmd.commit && tbl_we);
		mem_addr = cmd.sweep ? sweep_q : eff_code[KW-1:0];
		mem_data = cmd.sweep ? '0 : value_q[SW-1:0];
	end

	assign sts.sweep_last = (sweep_q == SWEEP_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
			thr_q   <= keq_pkg::THR_RESET;
			sweep_q <= '0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_q + KW'(1);
			end
			if (cmd.commit) begin
				acc_q   <= acc_next;
				head_q  <= head_next;
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_addr] <= mem_data;
		end
		if (cmd.commit && push) begin
			fifo_mem[slot] <= eff_code;
		end
		if (cmd.capture) begin
			act_q    <= keq_pkg::action_t'(action);
			type_q   <= event_type;
			code_q   <= event_code;
			value_q  <= event_value;
			tbl_rd_q <= tbl_mem[event_code[KW-1:0]];
			fifo_rd_q <= fifo_mem[head_q];
		end
		if (cmd.commit) begin
			key_valid_q   <= pop;
			key_code_q    <= pop ? fifo_rd_q : '0;
			key_state_q   <= state_rd;
			queued_q      <= push;
			dropped_q     <= drop;
			queue_count_q <= count_ext[keq_pkg::COUNT_W-1:0];
		end
	end

	assign key_valid   = key_valid_q;
	assign key_code    = key_code_q;
	assign key_state   = $signed(key_state_q);
	assign queued      = queued_q;
	assign dropped     = dropped_q;
	assign queue_count = queue_count_q;

endmodule

`default_nettype wire

FILE: rtl/key_event_queue_with_trackball.sv
// ----------------------------------------------------------------------------
// key_event_queue_with_trackball
// Keypad event front end: trackball Y motion to fake keys, key state table,
// key press queue.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the key state memory, one
// entry per cycle, over all NUM_KEYS entries (768 by default); no request is
// accepted until it finishes, while threshold writes are taken throughout.
// Each request then passes through the transfer cycle, which also reads the
// key state memory and the queue memory into registers, and the execute state
// that updates the accumulator, memories and queue pointers and loads the
// result register. The next request is accepted in the cycle after execute,
// even while the previous result still waits; execute holds only while the
// result register is still full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_queue_with_trackball #(
	parameter int QUEUE_DEPTH = keq_pkg::QUEUE_DEPTH,
	parameter int NUM_KEYS    = keq_pkg::NUM_KEYS
) (
	input wire logic clk,
	input wire logic arst_n,
	keq_evt_if.sink   req,
	keq_res_if.source rsp,
	keq_cfg_if.sink   cfg
);

	keq_pkg::cmd_t cmd;
	keq_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	keq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	keq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_KEYS    (NUM_KEYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg.data),
		.action      (req.action),
		.event_type  (req.event_type),
		.event_code  (req.event_code),
		.event_value (req.event_value),
		.key_valid   (rsp.key_valid),
		.key_code    (rsp.key_code),
		.key_state   (rsp.key_state),
		.queued      (rsp.queued),
		.dropped     (rsp.dropped),
		.queue_count (rsp.queue_count)
	);

endmodule

`default_nettype wire
